FILE: design/assert_macros.svh
// Assertion macros used by the loader top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

FILE: design/srec_pkg.sv
// Types, constants and character helpers for the S-record loader.
package srec_pkg;

  localparam int unsigned OFFSET_W  = 17;
  localparam int unsigned IMG_LEN_W = 18;
  localparam int unsigned ADDR_W    = 32;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_3  = 8'h33;
  localparam logic [7:0] CH_7  = 8'h37;
  localparam logic [7:0] CH_8  = 8'h38;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_FORMAT = 3'd1,
    ERR_BAD_HEADER = 3'd2,
    ERR_BELOW_BASE = 3'd3,
    ERR_TOO_LARGE  = 3'd4
  } err_e;

  typedef struct packed {
    kind_e                  kind;
    logic [OFFSET_W-1:0]    offset;
    logic [7:0]             data_byte;
    err_e                   error_code;
    logic [IMG_LEN_W-1:0]   image_length;
    logic [ADDR_W-1:0]      detected_base;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LA) && (c <= CH_LF_HEX)) ||
           ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  // Non-digits map to (c + 9) mod 16; case folding only touches bit 5.
  function automatic logic [3:0] nibble(input logic [7:0] c);
    return is_digit(c) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

endpackage

FILE: design/srecord_image_loader_top.sv
// S-record loader: character parser with a two-entry result buffer.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one text character per
//   transaction in ch_i, or an end-of-input mark in end_of_file_i.
//   Output channel (out_valid_o / out_stall_i) carries data-byte writes
//   (kind 0, with offset and data), a finish (kind 1) or an error (kind 2).
//   cfg_valid_i / cfg_ready_o writes the load base; zero means the first
//   record address becomes the base. Write it only while the block is idle.
// Timing:
//   One character per cycle while in_stall_o is low. Each result is registered
//   in the output register or, if that holds an untaken result, the skid
//   register. The two let the parser keep taking characters while the receiver
//   stalls; in_stall_o rises only when both hold a result.
// Reset:
//   Parser at start of line, base zero, image length zero, not halted.
//   After a finish or an error the block swallows input with no results
//   until the next reset.
module srecord_image_loader_top #(
  parameter int unsigned IMAGE_BYTES = 131072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [16:0] offset_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  error_code_o,
  output logic [17:0] image_length_o,
  output logic [31:0] detected_base_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned LenW = $clog2(IMAGE_BYTES + 1);
  localparam int unsigned AW   = srec_pkg::ADDR_W;

  typedef enum logic [3:0] {
    POS_START  = 4'd0,
    POS_TYPE   = 4'd1,
    POS_CNT_HI = 4'd2,
    POS_CNT_LO = 4'd3,
    POS_ADR_HI = 4'd4,
    POS_ADR_LO = 4'd5,
    POS_DAT_HI = 4'd6,
    POS_DAT_LO = 4'd7,
    POS_SKIP   = 4'd8
  } pos_e;

  pos_e            pos_q, pos_d;
  logic [1:0]      rtype_q, rtype_d;
  logic [7:0]      left_q, left_d;
  logic [2:0]      abl_q, abl_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [3:0]      hnib_q, hnib_d;
  logic [AW-1:0]   base_q, base_d;
  logic [LenW-1:0] len_q, len_d;
  logic            halted_q, halted_d;

  srec_pkg::result_t out_q, skid_q, res;
  logic              out_valid_q, skid_valid_q, res_valid;

  logic          in_fire, out_fire;
  logic [3:0]    nib;
  logic [7:0]    byte_val;
  logic [2:0]    abl_m1;
  logic [AW-1:0] addr_full, base_new, addr_rel, addr_inc;
  logic [AW:0]   end_sum;
  logic [8:0]    hdr_need;

  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_fire    = out_valid_q & ~out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign cfg_ready_o = 1'b1;

  assign nib       = srec_pkg::nibble(ch_i);
  assign byte_val  = {hnib_q, nib};
  assign abl_m1    = abl_q - 3'd1;
  assign addr_full = {addr_q[AW-9:0], hnib_q, nib};
  assign base_new  = (base_q == '0) ? addr_full : base_q;
  assign addr_rel  = addr_full - base_new;
  assign end_sum   = {1'b0, addr_rel} + (AW+1)'(left_q);
  assign addr_inc  = addr_q + AW'(1);
  assign hdr_need  = 9'(rtype_d) + 9'd2;

  always_comb begin
    pos_d     = pos_q;
    rtype_d   = rtype_q;
    left_d    = left_q;
    abl_d     = abl_q;
    addr_d    = addr_q;
    hnib_d    = hnib_q;
    base_d    = base_q;
    len_d     = len_q;
    halted_d  = halted_q;
    res_valid = 1'b0;
    res       = '0;

    if (in_fire && !halted_q) begin
      if (end_of_file_i) begin
        res_valid = 1'b1;
        if (pos_q == POS_TYPE || pos_q == POS_CNT_HI || pos_q == POS_CNT_LO) begin
          res.kind       = srec_pkg::KIND_ERROR;
          res.error_code = srec_pkg::ERR_BAD_HEADER;
        end else begin
          res.kind = srec_pkg::KIND_DONE;
        end
      end else begin
        unique case (pos_q)
          POS_START: begin
            if (ch_i == srec_pkg::CH_S) begin
              pos_d = POS_TYPE;
            end else if (ch_i != srec_pkg::CH_LF) begin
              res_valid = 1'b1;
              if (len_q == '0) begin
                res.kind = srec_pkg::KIND_DONE;
              end else begin
                res.kind       = srec_pkg::KIND_ERROR;
                res.error_code = srec_pkg::ERR_BAD_FORMAT;
              end
            end
          end
          POS_TYPE: begin
            if (ch_i == srec_pkg::CH_7 || ch_i == srec_pkg::CH_8 ||
                ch_i == srec_pkg::CH_9) begin
              res_valid = 1'b1;
              res.kind  = srec_pkg::KIND_DONE;
            end else if (ch_i == srec_pkg::CH_LF) begin
              res_valid      = 1'b1;
              res.kind       = srec_pkg::KIND_ERROR;
              res.error_code = srec_pkg::ERR_BAD_HEADER;
            end else begin
              rtype_d = (ch_i >= srec_pkg::CH_1 && ch_i <= srec_pkg::CH_3) ?
                        ch_i[1:0] : 2'd0;
              pos_d   = POS_CNT_HI;
            end
          end
          POS_CNT_HI, POS_CNT_LO: begin
            if (!srec_pkg::is_hex(ch_i)) begin
              res_valid      = 1'b1;
              res.kind       = srec_pkg::KIND_ERROR;
              res.error_code = srec_pkg::ERR_BAD_HEADER;
            end else if (pos_q == POS_CNT_HI) begin
              hnib_d = nib;
              pos_d  = POS_CNT_LO;
            end else if (rtype_q == 2'd0) begin
              pos_d = POS_SKIP;
            end else begin
              // count covers address bytes and checksum
              abl_d  = 3'(rtype_q) + 3'd1;
              left_d = (9'(byte_val) >= hdr_need) ? 8'(9'(byte_val) - hdr_need) : 8'd0;
              addr_d = '0;
              pos_d  = POS_ADR_HI;
            end
          end
          POS_ADR_HI, POS_DAT_HI: begin
            if (ch_i == srec_pkg::CH_LF) begin
              pos_d = POS_START;
            end else begin
              hnib_d = nib;
              pos_d  = (pos_q == POS_ADR_HI) ? POS_ADR_LO : POS_DAT_LO;
            end
          end
          POS_ADR_LO: begin
            if (ch_i == srec_pkg::CH_LF) begin
              pos_d = POS_START;
            end else begin
              abl_d = abl_m1;
              if (abl_m1 != 3'd0) begin
                addr_d = addr_full;
                pos_d  = POS_ADR_HI;
              end else begin
                base_d = base_new;
                addr_d = addr_rel;
                if (addr_full < base_new) begin
                  res_valid      = 1'b1;
                  res.kind       = srec_pkg::KIND_ERROR;
                  res.error_code = srec_pkg::ERR_BELOW_BASE;
                end else if (end_sum > (AW+1)'(IMAGE_BYTES)) begin
                  res_valid      = 1'b1;
                  res.kind       = srec_pkg::KIND_ERROR;
                  res.error_code = srec_pkg::ERR_TOO_LARGE;
                end else begin
                  pos_d = (left_q != '0) ? POS_DAT_HI : POS_SKIP;
                end
              end
            end
          end
          POS_DAT_LO: begin
            if (ch_i == srec_pkg::CH_LF) begin
              pos_d = POS_START;
            end else begin
              addr_d = addr_inc;
              if (addr_inc > AW'(len_q)) begin
                len_d = LenW'(addr_inc);
              end
              left_d        = left_q - 8'd1;
              pos_d         = (left_q != 8'd1) ? POS_DAT_HI : POS_SKIP;
              res_valid     = 1'b1;
              res.kind      = srec_pkg::KIND_DATA;
              res.offset    = srec_pkg::OFFSET_W'(addr_q);
              res.data_byte = byte_val;
            end
          end
          default: begin
            if (ch_i == srec_pkg::CH_LF) begin
              pos_d = POS_START;
            end
          end
        endcase
      end
    end

    res.image_length  = srec_pkg::IMG_LEN_W'(len_d);
    res.detected_base = base_d;
    if (res_valid && res.kind != srec_pkg::KIND_DATA) begin
      halted_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= POS_START;
      rtype_q      <= '0;
      left_q       <= '0;
      abl_q        <= '0;
      addr_q       <= '0;
      hnib_q       <= '0;
      base_q       <= '0;
      len_q        <= '0;
      halted_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else begin
      pos_q    <= pos_d;
      rtype_q  <= rtype_d;
      left_q   <= left_d;
      abl_q    <= abl_d;
      addr_q   <= addr_d;
      hnib_q   <= hnib_d;
      len_q    <= len_d;
      halted_q <= halted_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_data_i;
      end else begin
        base_q <= base_d;
      end
      // result buffer: skid entry drains first, in_stall_o holds input meanwhile
      if (skid_valid_q) begin
        if (out_fire) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (!out_valid_q || out_fire) begin
          out_q       <= res;
          out_valid_q <= 1'b1;
        end else begin
          skid_q       <= res;
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign offset_o        = out_q.offset;
  assign data_byte_o     = out_q.data_byte;
  assign error_code_o    = out_q.error_code;
  assign image_length_o  = out_q.image_length;
  assign detected_base_o = out_q.detected_base;

  `ASSERT_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q)
  `ASSERT_CLK(a_halt_sticks, halted_q |=> halted_q)
  `ASSERT_CLK(a_end_result_halts,
    (res_valid && res.kind != srec_pkg::KIND_DATA) |=> halted_q)
  `ASSERT_CLK(a_data_in_image,
    (pos_q == POS_DAT_HI || pos_q == POS_DAT_LO) |-> (addr_q < AW'(IMAGE_BYTES)))
  `ASSERT_NEVER(a_result_when_halted, halted_q && res_valid)

endmodule
